[src/cspk_pkg.sv]
// ----------------------------------------------------------------------------
// cspk_pkg
// shared types and constants of the code and symbol bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package cspk_pkg;

   // field widths of one input item
   localparam int CODE_W     = 16;
   localparam int CODE_BITS_W = 5;
   localparam int SYM_W      = 8;
   localparam int BYTE_W     = 8;

   // pending bits kept between items and the working window of one pair
   localparam int PEND_W     = BYTE_W - 1;
   localparam int PEND_CNT_W = $clog2(BYTE_W);
   localparam int ACC_W      = PEND_W + CODE_W + SYM_W;
   localparam int TOTAL_W    = $clog2(ACC_W + 1);

   // most bytes one pair can complete, and the byte counter width
   localparam int NBYTE_MAX  = ACC_W / BYTE_W;
   localparam int NBYTE_W    = TOTAL_W - PEND_CNT_W;
   localparam int RES_W      = NBYTE_MAX * BYTE_W;

   // stream word layout
   localparam int REQ_FIELDS_W = CODE_W + CODE_BITS_W + SYM_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      CMD_PAIR  = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [PEND_W-1:0]     bits;
      logic [PEND_CNT_W-1:0] count;
   } pend_type;

   typedef struct packed {
      logic [RES_W-1:0]   data;
      logic [NBYTE_W-1:0] nbytes;
   } res_type;

endpackage

`default_nettype wire

[src/code_symbol_bit_packer_core.sv]
// ----------------------------------------------------------------------------
// code_symbol_bit_packer_core
// lsb-first packer of code and symbol pairs into a byte stream
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                        tuser / tlast
// req_     in   code[15:0] code_bits[20:16] symbol[28:21] tuser: command
// rsp_     out  out_byte[7:0]                             tlast: last_of_run
//
// a word taken on req_ waits in the input register, then is packed
// combinationally into the result register, which sends out one byte a
// cycle while rsp_ is ready; a pair yields one to three bytes, so intake is
// paced by the one-byte result port. a flush sends the partial byte padded
// with zeros, or nothing if no bits are pending.
// reset is synchronous; it empties both registers and clears pending bits.
// a stall on rsp_ holds the result register and then the input register;
// the next word is taken in the same cycle the last byte of a run leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module code_symbol_bit_packer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // code[15:0], code_bits[20:16], symbol[28:21], zero pad[31:29]
   input  logic [cspk_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command: 0 pair, 1 flush
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_byte[7:0]
   output logic [cspk_pkg::BYTE_W-1:0]         rsp_tdata,
   output logic                                rsp_tlast
);

   // input register
   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   cspk_pkg::cmd_type                     in_cmd_ff;
   logic [cspk_pkg::CODE_W-1:0]           in_code_ff;
   logic [cspk_pkg::CODE_BITS_W-1:0]      in_cb_ff;
   logic [cspk_pkg::SYM_W-1:0]            in_sym_ff;

   // pending bits carried between items
   cspk_pkg::pend_type                    pend_ff;
   cspk_pkg::pend_type                    pend_in;
   cspk_pkg::pend_type                    pend_next;

   cspk_pkg::res_type                     res;
   logic                                  can_load;
   logic                                  adv;
   logic                                  take;

   // word moves from input register to result register
   assign adv        = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || adv;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in = take || (in_valid_ff && !adv);
   assign pend_in     = adv ? pend_next : pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
      end
      if (take) begin
         in_cmd_ff  <= cspk_pkg::cmd_type'(req_tuser);
         in_code_ff <= req_tdata[cspk_pkg::CODE_W-1:0];
         in_cb_ff   <= req_tdata[cspk_pkg::CODE_W +: cspk_pkg::CODE_BITS_W];
         in_sym_ff  <= req_tdata[cspk_pkg::CODE_W + cspk_pkg::CODE_BITS_W +:
                                 cspk_pkg::SYM_W];
      end
   end

   // merge pending, code and symbol bits
   cspk_pack u_pack (
      .cmd       (in_cmd_ff),
      .code      (in_code_ff),
      .code_bits (in_cb_ff),
      .symbol    (in_sym_ff),
      .pend      (pend_ff),
      .res       (res),
      .pend_next (pend_next)
   );

   // byte serializer on the result side
   cspk_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (adv),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // pending bits above the pending count are always zero
   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_ff.bits >> pend_ff.count) == '0)
      else $error("pending bits set above pending count");

   // a flush leaves nothing pending
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      adv && (in_cmd_ff == cspk_pkg::CMD_FLUSH) |=> pend_ff.count == '0)
      else $error("flush did not clear pending bits");

   // a pair always completes at least one byte
   a_pair_emits: assert property (@(posedge clock) disable iff (reset)
      adv && (in_cmd_ff == cspk_pkg::CMD_PAIR) |-> res.nbytes != '0)
      else $error("pair produced no byte");

   // a byte that is not the last of its run is followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("run ended without last marker");

endmodule

`default_nettype wire

[src/cspk_pack.sv]
// ----------------------------------------------------------------------------
// cspk_pack
// combinational packer: merges pending bits, code and symbol into bytes
// ----------------------------------------------------------------------------
`default_nettype none

module cspk_pack (
   input  cspk_pkg::cmd_type                    cmd,
   input  logic [cspk_pkg::CODE_W-1:0]          code,
   input  logic [cspk_pkg::CODE_BITS_W-1:0]     code_bits,
   input  logic [cspk_pkg::SYM_W-1:0]           symbol,
   input  cspk_pkg::pend_type                   pend,
   output cspk_pkg::res_type                    res,
   output cspk_pkg::pend_type                   pend_next
);

   logic [cspk_pkg::CODE_BITS_W-1:0] cb;
   logic [cspk_pkg::CODE_W-1:0]      code_mask;
   logic [cspk_pkg::CODE_W-1:0]      code_m;
   logic [cspk_pkg::ACC_W-1:0]       acc;
   logic [cspk_pkg::ACC_W-1:0]       rest;
   logic [cspk_pkg::TOTAL_W-1:0]     total;
   logic [cspk_pkg::TOTAL_W-1:0]     sym_pos;

   // zero length packs one bit, overlong saturates to the code width
   always_comb begin
      priority if (code_bits == '0) begin
         cb = cspk_pkg::CODE_BITS_W'(1);
      end else if (code_bits > cspk_pkg::CODE_BITS_W'(cspk_pkg::CODE_W)) begin
         cb = cspk_pkg::CODE_BITS_W'(cspk_pkg::CODE_W);
      end else begin
         cb = code_bits;
      end
   end

   assign code_mask = ~({cspk_pkg::CODE_W{1'b1}} << cb);
   assign code_m    = code & code_mask;
   assign sym_pos   = cspk_pkg::TOTAL_W'(pend.count) + cspk_pkg::TOTAL_W'(cb);
   assign total     = sym_pos + cspk_pkg::TOTAL_W'(cspk_pkg::SYM_W);

   assign acc = cspk_pkg::ACC_W'(pend.bits)
              | (cspk_pkg::ACC_W'(code_m) << pend.count)
              | (cspk_pkg::ACC_W'(symbol) << sym_pos);

   // drop the completed bytes, keep the leftover bits
   assign rest = acc >> {total[cspk_pkg::TOTAL_W-1:cspk_pkg::PEND_CNT_W],
                         cspk_pkg::PEND_CNT_W'(0)};

   always_comb begin
      unique case (cmd)
         cspk_pkg::CMD_FLUSH: begin
            res.data       = cspk_pkg::RES_W'(pend.bits);
            res.nbytes     = (pend.count != '0) ? cspk_pkg::NBYTE_W'(1) : '0;
            pend_next      = '0;
         end
         cspk_pkg::CMD_PAIR: begin
            res.data       = acc[cspk_pkg::RES_W-1:0];
            res.nbytes     = total[cspk_pkg::TOTAL_W-1:cspk_pkg::PEND_CNT_W];
            pend_next.bits = rest[cspk_pkg::PEND_W-1:0];
            pend_next.count = total[cspk_pkg::PEND_CNT_W-1:0];
         end
         default: begin
            res       = '0;
            pend_next = pend;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/cspk_out_buf.sv]
// ----------------------------------------------------------------------------
// cspk_out_buf
// result register: holds up to three bytes and, while rsp_tready is high, hands them out one a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cspk_out_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  cspk_pkg::res_type                  res,
   output logic                               can_load,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cspk_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast
);

   logic [cspk_pkg::RES_W-1:0]   data_ff;
   logic [cspk_pkg::RES_W-1:0]   data_in;
   logic [cspk_pkg::NBYTE_W-1:0] left_ff;
   logic [cspk_pkg::NBYTE_W-1:0] left_in;
   logic                         drain;

   assign drain    = rsp_tvalid && rsp_tready;
   assign can_load = (left_ff == '0)
                  || ((left_ff == cspk_pkg::NBYTE_W'(1)) && rsp_tready);

   always_comb begin
      priority if (load) begin
         data_in = res.data;
         left_in = res.nbytes;
      end else if (drain) begin
         data_in = data_ff >> cspk_pkg::BYTE_W;
         left_in = left_ff - cspk_pkg::NBYTE_W'(1);
      end else begin
         data_in = data_ff;
         left_in = left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = (left_ff != '0);
   assign rsp_tdata  = data_ff[cspk_pkg::BYTE_W-1:0];
   assign rsp_tlast  = (left_ff == cspk_pkg::NBYTE_W'(1));

endmodule

`default_nettype wire

[sim/code_symbol_bit_packer_core_tb.sv]
// ----------------------------------------------------------------------------
// code_symbol_bit_packer_core_tb
// self-checking bench for the lsb-first code and symbol bit packer
// ----------------------------------------------------------------------------
// a short table of hand-picked words goes in first: flushes with and without
// pending bits, full-width and saturated code lengths, zero length, and ignored
// fields on flush. rows whose bytes are obvious carry them typed in, the rest
// go through a local model of the pending-bit packer. random pair and flush
// words follow under four mixes of sender gaps and receiver stalls. every byte
// taken from rsp_ is compared with the oldest predicted byte and its tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module code_symbol_bit_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RAND_PER_MIX = 125;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;

   // one word for the input channel, optionally with its bytes typed in
   typedef struct {
      cspk_pkg::cmd_type cmd;
      logic [15:0]       code;
      logic [4:0]        len;
      logic [7:0]        sym;
      bit                typed;
      int                nexp;
      logic [23:0]       exp;    // typed bytes, first byte in the low bits
   } pack_word_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cspk_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [cspk_pkg::BYTE_W-1:0]     rsp_tdata;
   logic                            rsp_tlast;

   pack_word_type word_q[$];       // words handed to the sender, oldest first
   pack_word_type dir_rows[$];     // directed table
   out_byte_type  packed_byte_q[$];

   // model state of the packer
   logic [6:0] pend_bits = '0;
   logic [2:0] pend_cnt  = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int err_count     = 0;
   int cycle_count   = 0;
   int pair_count    = 0;
   int flush_count   = 0;
   int byte_count    = 0;

   code_symbol_bit_packer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // packs one word into the pending bits and returns the bytes it completes
   function automatic int pack_bits(input cspk_pkg::cmd_type cmd,
                                    input logic [15:0] code,
                                    input logic [4:0] len, input logic [7:0] sym,
                                    output logic [23:0] bytes);
      logic [31:0] acc;
      int          cnt;
      int          nbits;
      int          n;
      acc   = {25'd0, pend_bits};
      cnt   = int'(pend_cnt);
      n     = 0;
      bytes = '0;
      if (cmd == cspk_pkg::CMD_FLUSH) begin
         // nothing pending means nothing to send
         if (cnt != 0) begin
            bytes[7:0] = acc[7:0];
            n = 1;
         end
         pend_bits = '0;
         pend_cnt  = '0;
         return n;
      end
      // zero length packs one bit, long lengths clip to the code width
      nbits = (len == 5'd0) ? 1 :
              ((int'(len) > cspk_pkg::CODE_W) ? cspk_pkg::CODE_W : int'(len));
      acc = acc | ((32'(code) & ((32'h1 << nbits) - 32'h1)) << cnt);
      cnt = cnt + nbits;
      acc = acc | (32'(sym) << cnt);
      cnt = cnt + cspk_pkg::SYM_W;
      while (cnt >= cspk_pkg::BYTE_W) begin
         bytes[n*8 +: 8] = acc[7:0];
         acc = acc >> 8;
         cnt = cnt - cspk_pkg::BYTE_W;
         n++;
      end
      pend_bits = acc[6:0];
      pend_cnt  = cnt[2:0];
      return n;
   endfunction

   task automatic add_row(input cspk_pkg::cmd_type cmd, input logic [15:0] code,
                          input logic [4:0] len, input logic [7:0] sym,
                          input bit typed, input int nexp, input logic [23:0] exp);
      pack_word_type w;
      w.cmd = cmd; w.code = code; w.len = len; w.sym = sym;
      w.typed = typed; w.nexp = nexp; w.exp = exp;
      dir_rows.push_back(w);
   endtask

   // drives one word, with random gaps ahead of it, and waits for the handshake
   task automatic send_word(input pack_word_type w);
      word_q.push_back(w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tdata  <= {3'b000, w.sym, w.len, w.code};
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // predicts on every accepted input word, checks every accepted output byte
   always @(posedge clock) begin : monitor
      pack_word_type w;
      logic [23:0]   pred;
      int            n;
      out_byte_type  ob;
      out_byte_type  want;
      if (!reset) begin
         if (req_tvalid && req_tready && word_q.size() > 0) begin
            w = word_q.pop_front();
            n = pack_bits(w.cmd, w.code, w.len, w.sym, pred);
            // typed rows trust the table, the model only keeps its state
            if (w.typed) begin
               n    = w.nexp;
               pred = w.exp;
            end
            for (int i = 0; i < n; i++) begin
               ob.data = pred[i*8 +: 8];
               ob.last = (i == n - 1);
               packed_byte_q.push_back(ob);
            end
            if (w.cmd == cspk_pkg::CMD_FLUSH) flush_count++;
            else pair_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            byte_count++;
            if (packed_byte_q.size() == 0) begin
               $display("%0t: unexpected byte, expected none, got %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               want = packed_byte_q.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                           $time, want.data, want.last, rsp_tdata, rsp_tlast);
                  err_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d bytes still expected", $time,
                  packed_byte_q.size());
         $display("code_symbol_bit_packer_core: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      pack_word_type w;
      int r;

      // flushes, extremes and the typed cases first
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 1, 0, 24'h000000); // nothing pending
      add_row(cspk_pkg::CMD_PAIR,  16'hFFFF, 5'd16, 8'hFF, 1, 3, 24'hFFFFFF);
      add_row(cspk_pkg::CMD_PAIR,  16'hFFFF, 5'd31, 8'h00, 1, 3, 24'h00FFFF); // length clips
      add_row(cspk_pkg::CMD_PAIR,  16'h0000, 5'd16, 8'h00, 1, 3, 24'h000000);
      add_row(cspk_pkg::CMD_PAIR,  16'h0000, 5'd0,  8'hA5, 1, 1, 24'h00004A); // zero length
      add_row(cspk_pkg::CMD_FLUSH, 16'hFFFF, 5'd31, 8'hFF, 1, 1, 24'h000001); // fields ignored
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 1, 0, 24'h000000);
      add_row(cspk_pkg::CMD_PAIR,  16'h0001, 5'd1,  8'h00, 1, 1, 24'h000001);
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 1, 1, 24'h000000); // zero pad only
      // mixed lengths and pending counts, checked by the model
      add_row(cspk_pkg::CMD_PAIR,  16'h003F, 5'd6,  8'h81, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h1234, 5'd17, 8'h5A, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'hFFFF, 5'd15, 8'hFF, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h8000, 5'd16, 8'h01, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h0AAA, 5'd12, 8'hC3, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_FLUSH, 16'hFFFF, 5'd31, 8'hFF, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h5555, 5'd7,  8'h00, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h0000, 5'd24, 8'hFF, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h7FFF, 5'd16, 8'h80, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h0001, 5'd2,  8'h7E, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'hA5A5, 5'd16, 8'h5A, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_PAIR,  16'h0000, 5'd1,  8'hFF, 0, 0, 24'h0);
      add_row(cspk_pkg::CMD_FLUSH, 16'h0000, 5'd0,  8'h00, 0, 0, 24'h0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_word(dir_rows[i]);

      // random words under four idling mixes
      for (int mix = 0; mix < 4; mix++) begin
         unique case (mix)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         for (int k = 0; k < RAND_PER_MIX; k++) begin
            w.cmd  = ($urandom_range(99) < 15) ? cspk_pkg::CMD_FLUSH : cspk_pkg::CMD_PAIR;
            w.code = 16'($urandom_range(16'hFFFF));
            r      = int'($urandom_range(99));
            // mostly legal lengths, some zero or oversize
            w.len  = (r < 80) ? 5'($urandom_range(16, 1)) : 5'($urandom_range(31));
            w.sym  = 8'($urandom_range(8'hFF));
            w.typed = 0;
            w.nexp  = 0;
            w.exp   = '0;
            send_word(w);
         end
      end
      req_tvalid <= 1'b0;

      while (word_q.size() > 0 || packed_byte_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d pair and %0d flush words through four idling mixes",
               pair_count, flush_count);
      $display("compared %0d packed bytes, %0d errors", byte_count, err_count);
      if (err_count == 0 && packed_byte_q.size() == 0) begin
         $display("code_symbol_bit_packer_core: match");
      end else begin
         $display("code_symbol_bit_packer_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
src/cspk_pkg.sv
src/cspk_pack.sv
src/cspk_out_buf.sv
src/code_symbol_bit_packer_core.sv
sim/code_symbol_bit_packer_core_tb.sv
